// File: rtl/dibpu_pkg.sv
// Shared types, constants and helper functions of the DIB pixel unpacker.
package dibpu_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int COLOR_W       = 24;
  localparam int COL_W         = 12;
  localparam int ROW_W         = 12;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_BITS_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_PIXELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 2'd2;

  localparam logic [2:0]            BITS_MODE_RST  = 3'd2;
  localparam logic [CFG_DATA_W-1:0] ROW_PIXELS_RST = 13'd160;
  localparam logic [CFG_DATA_W-1:0] FRAME_ROWS_RST = 13'd120;

  typedef enum logic [2:0] {
    FMT_1BPP  = 3'd0,
    FMT_4BPP  = 3'd1,
    FMT_8BPP  = 3'd2,
    FMT_16BPP = 3'd3,
    FMT_24BPP = 3'd4,
    FMT_32BPP = 3'd5
  } fmt_t;

  // One data byte's worth of pixels, handed from the byte walker to the emitter
  typedef struct packed {
    fmt_t               fmt;
    logic [7:0]         pix_bits;
    logic [COLOR_W-1:0] rgb;
    logic [3:0]         count;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic               frame_end;
  } pix_desc_t;

  localparam logic [7:0] EXPAND5 [32] = '{
    8'd0,   8'd16,  8'd24,  8'd32,  8'd40,  8'd48,  8'd56,  8'd64,
    8'd72,  8'd80,  8'd88,  8'd96,  8'd104, 8'd112, 8'd120, 8'd128,
    8'd136, 8'd144, 8'd152, 8'd160, 8'd168, 8'd176, 8'd184, 8'd192,
    8'd200, 8'd208, 8'd216, 8'd224, 8'd232, 8'd240, 8'd248, 8'd255
  };

  function automatic logic [7:0] expand5(input logic [4:0] f);
    return EXPAND5[f];
  endfunction

  // Unused mode codes fall back to 8 bits per pixel
  function automatic fmt_t mode_to_fmt(input logic [2:0] mode);
    fmt_t f;
    case (mode)
      3'd0:    f = FMT_1BPP;
      3'd1:    f = FMT_4BPP;
      3'd3:    f = FMT_16BPP;
      3'd4:    f = FMT_24BPP;
      3'd5:    f = FMT_32BPP;
      default: f = FMT_8BPP;
    endcase
    return f;
  endfunction

endpackage

// File: rtl/dibpu_if.sv
// Valid/ready channel interfaces for the input items and the output pixels.
interface dibpu_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  palette_index;
  logic [23:0] palette_color;
  logic [7:0]  data_byte;

  modport source (output valid, kind, palette_index, palette_color, data_byte,
                  input ready);
  modport sink   (input valid, kind, palette_index, palette_color, data_byte,
                  output ready);
endinterface

interface dibpu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [11:0] column;
  logic [11:0] row;
  logic        last;
  logic        frame_end;

  modport source (output valid, red, green, blue, column, row, last, frame_end,
                  input ready);
  modport sink   (input valid, red, green, blue, column, row, last, frame_end,
                  output ready);
endinterface

// File: rtl/dib_pixel_unpacker_core.sv
// Top level of the DIB pixel unpacker: configuration, palette memory and pixel path.
//
// Input channel (in_ch): one transaction is a palette write (kind 0: palette_index,
// palette_color) or one bitmap byte in memory order (kind 1: data_byte). Bytes of a
// bottom-up bitmap arrive row by row; padding up to the 4-byte stride is dropped.
// Output channel (out_ch): one transaction per RGB888 pixel with its column and its
// top-down row; last marks the final pixel of a byte, frame_end the final pixel of
// the frame.
// Configuration (cfg_*): bits_mode, row width in pixels and frame height in rows,
// written one per cycle while no transaction is in flight; a write takes effect for
// the very next byte.
// Throughput: one byte per cycle while each byte yields at most one pixel and
// out_ch.ready is high; a byte that yields more pixels (up to 8 in 1-bit mode, 2 in
// 4-bit mode) holds the input until its last pixel is pushed, as the single output
// register retires one pixel per cycle while out_ch.ready is high.
// Palette reads go through a two-port memory, so 1- and 4-bit bytes fetch both
// colors in one access.
// Reset: position, partial pixel and handshake state clear; the registers return
// to 8 bits per pixel, 160 by 120. The palette is not cleared.
// Stall: when out_ch.ready is low the output register holds, the pixel stage
// behind it fills, and in_ch.ready drops until the stall clears.
module dib_pixel_unpacker_core #(
  parameter int MAX_WIDTH  = dibpu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dibpu_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  dibpu_in_if.sink                             in_ch,
  dibpu_out_if.source                          out_ch,
  input  logic                                 cfg_wr_en,
  input  logic [dibpu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dibpu_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
  import dibpu_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH+1);
  localparam int HW = $clog2(MAX_HEIGHT+1);
  localparam int BW = $clog2(MAX_WIDTH*4+4);
  localparam int TW = CW + 6;

  // Configuration registers and the row geometry derived from them
  logic [2:0]            bits_mode_r,    bits_mode_nxt;
  logic [CFG_DATA_W-1:0] row_pixels_r,   row_pixels_nxt;
  logic [CFG_DATA_W-1:0] frame_rows_r,   frame_rows_nxt;
  fmt_t                  fmt_r,          fmt_nxt;
  logic [CW-1:0]         eff_w_r,        eff_w_nxt;
  logic [HW-1:0]         eff_h_r,        eff_h_nxt;
  logic [BW-1:0]         used_r,         used_nxt;
  logic [BW-1:0]         stride_r,       stride_nxt;
  logic [TW-1:0]         w_ext;
  logic [TW-1:0]         row_bits;

  logic                  take_any;
  logic                  take_byte;
  logic                  pal_wr;
  logic                  can_accept;
  logic                  desc_valid;
  pix_desc_t             desc;
  logic [PAL_AW-1:0]     rd_addr0;
  logic [PAL_AW-1:0]     rd_addr1;
  logic [COLOR_W-1:0]    rd_data0;
  logic [COLOR_W-1:0]    rd_data1;

  // Register writes; reset loads the defaults through the same path
  always_comb begin
    bits_mode_nxt  = bits_mode_r;
    row_pixels_nxt = row_pixels_r;
    frame_rows_nxt = frame_rows_r;
    if (!rst_n) begin
      bits_mode_nxt  = BITS_MODE_RST;
      row_pixels_nxt = ROW_PIXELS_RST;
      frame_rows_nxt = FRAME_ROWS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BITS_MODE:  bits_mode_nxt  = cfg_wr_data[2:0];
        CFG_ROW_PIXELS: row_pixels_nxt = cfg_wr_data;
        CFG_FRAME_ROWS: frame_rows_nxt = cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Clamp width and height into 1..MAX
  always_comb begin
    if (row_pixels_nxt == '0) begin
      eff_w_nxt = CW'(1);
    end else if (32'(row_pixels_nxt) > 32'(MAX_WIDTH)) begin
      eff_w_nxt = CW'(MAX_WIDTH);
    end else begin
      eff_w_nxt = CW'(row_pixels_nxt);
    end
    if (frame_rows_nxt == '0) begin
      eff_h_nxt = HW'(1);
    end else if (32'(frame_rows_nxt) > 32'(MAX_HEIGHT)) begin
      eff_h_nxt = HW'(MAX_HEIGHT);
    end else begin
      eff_h_nxt = HW'(frame_rows_nxt);
    end
  end

  assign fmt_nxt = mode_to_fmt(bits_mode_nxt);
  assign w_ext   = TW'(eff_w_nxt);

  // Bits per row: width times bits per pixel, all by shifts
  always_comb begin
    case (fmt_nxt)
      FMT_1BPP:  row_bits = w_ext;
      FMT_4BPP:  row_bits = w_ext << 2;
      FMT_8BPP:  row_bits = w_ext << 3;
      FMT_16BPP: row_bits = w_ext << 4;
      FMT_24BPP: row_bits = (w_ext << 4) + (w_ext << 3);
      FMT_32BPP: row_bits = w_ext << 5;
      default:   row_bits = w_ext << 3;
    endcase
  end

  // Bytes carrying pixels, then the row stride rounded up to 4 bytes
  assign used_nxt   = BW'((row_bits + TW'(7)) >> 3);
  assign stride_nxt = (used_nxt + BW'(3)) & ~BW'(3);

  always_ff @(posedge clk) begin
    bits_mode_r  <= bits_mode_nxt;
    row_pixels_r <= row_pixels_nxt;
    frame_rows_r <= frame_rows_nxt;
    fmt_r        <= fmt_nxt;
    eff_w_r      <= eff_w_nxt;
    eff_h_r      <= eff_h_nxt;
    used_r       <= used_nxt;
    stride_r     <= stride_nxt;
  end

  // Handshake: take a transaction whenever the pixel stage frees up this cycle
  assign in_ch.ready = can_accept;
  assign take_any    = in_ch.valid && can_accept;
  assign take_byte   = take_any && in_ch.kind;
  assign pal_wr      = take_any && !in_ch.kind;

  dibpu_palette_ram u_palette (
    .clk      (clk),
    .wr_en    (pal_wr),
    .wr_addr  (in_ch.palette_index),
    .wr_data  (in_ch.palette_color),
    .rd_en    (take_byte),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

  dibpu_byte_walker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take_byte),
    .data_byte  (in_ch.data_byte),
    .fmt        (fmt_r),
    .eff_w      (eff_w_r),
    .eff_h      (eff_h_r),
    .used       (used_r),
    .stride     (stride_r),
    .desc_valid (desc_valid),
    .desc       (desc),
    .rd_addr0   (rd_addr0),
    .rd_addr1   (rd_addr1)
  );

  // Bytes that yield no pixel (padding, partial direct pixels) stop at the walker
  dibpu_pixel_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (take_byte && desc_valid),
    .desc       (desc),
    .rd_data0   (rd_data0),
    .rd_data1   (rd_data1),
    .can_accept (can_accept),
    .out_ch     (out_ch)
  );

endmodule

// File: rtl/dibpu_palette_ram.sv
// Palette memory: one write port, two registered read ports.
module dibpu_palette_ram (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [dibpu_pkg::PAL_AW-1:0]        wr_addr,
  input  logic [dibpu_pkg::COLOR_W-1:0]       wr_data,
  input  logic                                rd_en,
  input  logic [dibpu_pkg::PAL_AW-1:0]        rd_addr0,
  input  logic [dibpu_pkg::PAL_AW-1:0]        rd_addr1,
  output logic [dibpu_pkg::COLOR_W-1:0]       rd_data0,
  output logic [dibpu_pkg::COLOR_W-1:0]       rd_data1
);
  import dibpu_pkg::*;

  logic [COLOR_W-1:0] mem [PALETTE_DEPTH];
  logic [COLOR_W-1:0] rd_data0_r;
  logic [COLOR_W-1:0] rd_data1_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next read so a long pixel burst keeps its colors
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0_r <= mem[rd_addr0];
      rd_data1_r <= mem[rd_addr1];
    end
  end

  assign rd_data0 = rd_data0_r;
  assign rd_data1 = rd_data1_r;

endmodule

// File: rtl/dibpu_byte_walker.sv
// Byte walker: tracks the row position per data byte and builds pixel descriptors.
module dibpu_byte_walker #(
  parameter int MAX_WIDTH  = dibpu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dibpu_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    take,
  input  logic [7:0]                              data_byte,
  input  dibpu_pkg::fmt_t                         fmt,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]          eff_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]         eff_h,
  input  logic [$clog2(MAX_WIDTH*4+4)-1:0]        used,
  input  logic [$clog2(MAX_WIDTH*4+4)-1:0]        stride,
  output logic                                    desc_valid,
  output dibpu_pkg::pix_desc_t                    desc,
  output logic [dibpu_pkg::PAL_AW-1:0]            rd_addr0,
  output logic [dibpu_pkg::PAL_AW-1:0]            rd_addr1
);
  import dibpu_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH+1);
  localparam int HW = $clog2(MAX_HEIGHT+1);
  localparam int BW = $clog2(MAX_WIDTH*4+4);

  logic [BW-1:0]      byte_in_row_r, byte_in_row_nxt;
  logic [HW-1:0]      source_row_r,  source_row_nxt;
  logic [CW-1:0]      pixel_column_r, pixel_column_nxt;
  logic [COLOR_W-1:0] partial_pixel_r, partial_pixel_nxt;
  logic [1:0]         byte_phase_r,  byte_phase_nxt;

  logic               in_data;
  logic               direct;
  logic               complete;
  logic [2:0]         nbytes;
  logic [2:0]         phase_inc;
  logic [3:0]         cap;
  logic [3:0]         n;
  logic [CW-1:0]      room;
  logic [CW-1:0]      pc_adv;
  logic [BW-1:0]      bir_inc;
  logic               row_end;
  logic [HW-1:0]      sr_inc;
  logic [HW-1:0]      row_full;
  logic               sr_ge_h;
  logic               last_row;
  logic [COLOR_W-1:0] shifted;
  logic [15:0]        word16;
  logic [COLOR_W-1:0] rgb;

  assign in_data = byte_in_row_r < used;
  assign direct  = (fmt == FMT_16BPP) || (fmt == FMT_24BPP) || (fmt == FMT_32BPP);

  always_comb begin
    case (fmt)
      FMT_16BPP: nbytes = 3'd2;
      FMT_24BPP: nbytes = 3'd3;
      default:   nbytes = 3'd4;
    endcase
  end

  assign phase_inc = {1'b0, byte_phase_r} + 3'd1;
  assign complete  = phase_inc >= nbytes;

  // Pixels this byte can yield, before clipping at the row's width
  always_comb begin
    case (fmt)
      FMT_1BPP: cap = 4'd8;
      FMT_4BPP: cap = 4'd2;
      FMT_8BPP: cap = 4'd1;
      default:  cap = complete ? 4'd1 : 4'd0;
    endcase
  end

  assign room = (pixel_column_r < eff_w) ? (eff_w - pixel_column_r) : '0;

  always_comb begin
    if (!in_data) begin
      n = '0;
    end else if (CW'(cap) > room) begin
      n = room[3:0];
    end else begin
      n = cap;
    end
  end

  assign pc_adv = pixel_column_r + CW'(n);

  // Direct-color assembly
  always_comb begin
    case (byte_phase_r)
      2'd0:    shifted = {16'd0, data_byte};
      2'd1:    shifted = {8'd0, data_byte, 8'd0};
      2'd2:    shifted = {data_byte, 16'd0};
      default: shifted = '0;
    endcase
  end

  assign word16 = {data_byte, partial_pixel_r[7:0]};

  always_comb begin
    case (fmt)
      FMT_16BPP: rgb = {expand5(word16[14:10]), expand5(word16[9:5]), expand5(word16[4:0])};
      FMT_24BPP: rgb = {data_byte, partial_pixel_r[15:0]};
      default:   rgb = partial_pixel_r;
    endcase
  end

  // Top-down row; a row beyond the height reads as row 0 and closes the frame
  assign sr_inc   = source_row_r + HW'(1);
  assign sr_ge_h  = source_row_r >= eff_h;
  assign row_full = eff_h - HW'(1) - source_row_r;
  assign last_row = sr_ge_h || (sr_inc >= eff_h);

  assign bir_inc = byte_in_row_r + BW'(1);
  assign row_end = bir_inc >= stride;

  always_comb begin
    partial_pixel_nxt = partial_pixel_r;
    byte_phase_nxt    = byte_phase_r;
    if (in_data && direct) begin
      if (complete) begin
        partial_pixel_nxt = '0;
        byte_phase_nxt    = '0;
      end else begin
        partial_pixel_nxt = partial_pixel_r | shifted;
        byte_phase_nxt    = phase_inc[1:0];
      end
    end
    pixel_column_nxt = pc_adv;
    byte_in_row_nxt  = bir_inc;
    source_row_nxt   = source_row_r;
    if (row_end) begin
      byte_in_row_nxt   = '0;
      pixel_column_nxt  = '0;
      partial_pixel_nxt = '0;
      byte_phase_nxt    = '0;
      source_row_nxt    = (sr_inc >= eff_h) ? '0 : sr_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_in_row_r   <= '0;
      source_row_r    <= '0;
      pixel_column_r  <= '0;
      partial_pixel_r <= '0;
      byte_phase_r    <= '0;
    end else if (take) begin
      byte_in_row_r   <= byte_in_row_nxt;
      source_row_r    <= source_row_nxt;
      pixel_column_r  <= pixel_column_nxt;
      partial_pixel_r <= partial_pixel_nxt;
      byte_phase_r    <= byte_phase_nxt;
    end
  end

  always_comb begin
    case (fmt)
      FMT_1BPP: begin
        rd_addr0 = PAL_AW'(0);
        rd_addr1 = PAL_AW'(1);
      end
      FMT_4BPP: begin
        rd_addr0 = PAL_AW'(data_byte[7:4]);
        rd_addr1 = PAL_AW'(data_byte[3:0]);
      end
      default: begin
        rd_addr0 = data_byte;
        rd_addr1 = data_byte;
      end
    endcase
  end

  assign desc_valid     = n != 4'd0;
  assign desc.fmt       = fmt;
  assign desc.pix_bits  = data_byte;
  assign desc.rgb       = rgb;
  assign desc.count     = n;
  assign desc.col       = COL_W'(pixel_column_r);
  assign desc.row       = sr_ge_h ? '0 : ROW_W'(row_full);
  assign desc.frame_end = last_row && (pc_adv == eff_w);

endmodule

// File: rtl/dibpu_pixel_emitter.sv
// Pixel emitter: walks one byte's pixels out through the output register.
module dibpu_pixel_emitter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  dibpu_pkg::pix_desc_t            desc,
  input  logic [dibpu_pkg::COLOR_W-1:0]   rd_data0,
  input  logic [dibpu_pkg::COLOR_W-1:0]   rd_data1,
  output logic                            can_accept,
  dibpu_out_if.source                     out_ch
);
  import dibpu_pkg::*;

  logic               b_valid_r, b_valid_nxt;
  logic [2:0]         idx_r, idx_nxt;
  pix_desc_t          desc_r;
  logic               out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0] out_color_r;
  logic [COL_W-1:0]   out_col_r;
  logic [ROW_W-1:0]   out_row_r;
  logic               out_last_r;
  logic               out_fe_r;

  logic               out_take;
  logic               push;
  logic               last_px;
  logic               b_done;
  logic [COLOR_W-1:0] color;

  assign out_take   = !out_valid_r || out_ch.ready;
  assign push       = b_valid_r && out_take;
  assign last_px    = {1'b0, idx_r} == (desc_r.count - 4'd1);
  assign b_done     = push && last_px;
  assign can_accept = !b_valid_r || b_done;

  always_comb begin
    case (desc_r.fmt)
      FMT_1BPP: color = desc_r.pix_bits[3'd7 - idx_r] ? rd_data1 : rd_data0;
      FMT_4BPP: color = idx_r[0] ? rd_data1 : rd_data0;
      FMT_8BPP: color = rd_data0;
      default:  color = desc_r.rgb;
    endcase
  end

  always_comb begin
    b_valid_nxt = b_valid_r;
    idx_nxt     = idx_r;
    if (push) begin
      idx_nxt = last_px ? 3'd0 : idx_r + 3'd1;
    end
    if (b_done) begin
      b_valid_nxt = 1'b0;
    end
    if (load) begin
      b_valid_nxt = 1'b1;
      idx_nxt     = 3'd0;
    end
    out_valid_nxt = push ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      b_valid_r   <= b_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc_r <= desc;
    end
    if (push) begin
      out_color_r <= color;
      out_col_r   <= desc_r.col + COL_W'(idx_r);
      out_row_r   <= desc_r.row;
      out_last_r  <= last_px;
      out_fe_r    <= last_px && desc_r.frame_end;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.red       = out_color_r[23:16];
  assign out_ch.green     = out_color_r[15:8];
  assign out_ch.blue      = out_color_r[7:0];
  assign out_ch.column    = out_col_r;
  assign out_ch.row       = out_row_r;
  assign out_ch.last      = out_last_r;
  assign out_ch.frame_end = out_fe_r;

endmodule
